// File: rtl/assert_macros.svh
// Assertion macros shared by the timer queue modules.
// Depends on nothing; included by the files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication in the same cycle.
`define QA_IMPLY(lbl, ck, rn, a, b, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (a) |-> (b)) else $error(msg);
// Implication to the following cycle.
`define QA_NEXT(lbl, ck, rn, a, b, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (a) |=> (b)) else $error(msg);
`endif

// File: rtl/qhtq_pkg.sv
// Types and constants of the timer queue.
// Used by qhtq_cyc, the top level and the testbench; depends on nothing.
package qhtq_pkg;
	localparam int ID_W  = 10;
	localparam int DL_W  = 64;
	localparam int ST_W  = 3;
	localparam int CPU_W = 16;
	localparam int LIM_W = 7;
	localparam int CFG_W = 64;
	localparam int CIX_W = 2;
	localparam int MD_W  = 2;

	localparam logic [MD_W-1:0] MODE_ARM    = 2'd0;
	localparam logic [MD_W-1:0] MODE_CANCEL = 2'd1;
	localparam logic [MD_W-1:0] MODE_EXPIRE = 2'd2;

	localparam logic [ST_W-1:0] ST_ARMED     = 3'd0;
	localparam logic [ST_W-1:0] ST_FULL      = 3'd1;
	localparam logic [ST_W-1:0] ST_ALREADY   = 3'd2;
	localparam logic [ST_W-1:0] ST_CANCELLED = 3'd3;
	localparam logic [ST_W-1:0] ST_NOT_ARMED = 3'd4;
	localparam logic [ST_W-1:0] ST_FIRED     = 3'd5;

	localparam logic [CIX_W-1:0] CFG_CPU    = 2'd0;
	localparam logic [CIX_W-1:0] CFG_OFFSET = 2'd1;
	localparam logic [CIX_W-1:0] CFG_LIMIT  = 2'd2;

	localparam logic [LIM_W-1:0] MAX_FIRE = 7'd64;

	typedef struct packed {
		logic [DL_W-1:0] dl;
		logic [ID_W-1:0] ow;
	} heap_ent_t;
endpackage

// File: rtl/qhtq_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
// Depends on nothing.
module qhtq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// File: rtl/qhtq_cyc.sv
// Two-stage conversion of a deadline in microseconds to clock cycles, modulo 2^64.
// Depends on qhtq_pkg.
module qhtq_cyc (
	input  logic                         clk,
	input  logic [qhtq_pkg::DL_W-1:0]    dl,
	input  logic [qhtq_pkg::CPU_W-1:0]   cpu,
	output logic [qhtq_pkg::DL_W-1:0]    prod
);
	import qhtq_pkg::*;

	logic [47:0] lo_s1;
	logic [31:0] hi_s1;
	logic [47:0] hi_full;

	assign hi_full = dl[63:32] * cpu;

	always_ff @(posedge clk) begin
		lo_s1 <= dl[31:0] * cpu;
		hi_s1 <= hi_full[31:0];
		prod  <= 64'(lo_s1) + {hi_s1, 32'd0};
	end
endmodule

// File: rtl/quad_heap_timer_queue.sv
// Top level of the timer queue: control sequencer, heap and timer table memories.
// Depends on qhtq_pkg, qhtq_ram, qhtq_cyc and assert_macros.svh.
//
// After reset the block clears every entry of its timer table with busy high, then
// takes one item at a time. An arm climbs the heap level by level, reading and
// comparing each parent; a cancel moves the last entry into the freed slot and
// climbs or sifts it down, and each timer fired by an expire sifts down, reading the
// children of each level one by one, since the heap memory gives one read a cycle.
// Every result then passes the root read and the two-stage cycle conversion. Each
// result is shown for a single cycle on done and cannot be held off; the results of
// one expire come one after another and busy stays high until the one marked last.
`include "assert_macros.svh"
module quad_heap_timer_queue #(
	parameter int MAX_TIMERS = 1024,
	parameter int HEAP_ARITY = 4
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [qhtq_pkg::MD_W-1:0]     mode,
	input  logic [qhtq_pkg::ID_W-1:0]     timer_id,
	input  logic [qhtq_pkg::DL_W-1:0]     due_us,
	input  logic [qhtq_pkg::DL_W-1:0]     now_us,
	input  logic                          cfg_we,
	input  logic [qhtq_pkg::CIX_W-1:0]    cfg_index,
	input  logic [qhtq_pkg::CFG_W-1:0]    cfg_data,
	output logic                          done,
	output logic [qhtq_pkg::ST_W-1:0]     status,
	output logic [qhtq_pkg::ID_W-1:0]     fired_id,
	output logic [qhtq_pkg::DL_W-1:0]     earliest_deadline,
	output logic [qhtq_pkg::DL_W-1:0]     next_event_cycle,
	output logic                          fired_none,
	output logic                          last
);
	import qhtq_pkg::*;

	localparam int AW  = $clog2(MAX_TIMERS);
	localparam int CW  = AW + 4;
	localparam int KW  = 4;
	localparam int SH  = AW + 3;
	localparam int RW  = SH + 1;
	localparam logic [RW-1:0] RECIP = RW'(((1 << SH) + HEAP_ARITY - 1) / HEAP_ARITY);
	localparam logic [AW-1:0] CNT_MAX = AW'(MAX_TIMERS - 1);
	localparam int HW  = DL_W + ID_W;

	localparam logic [3:0] S_CLR    = 4'd0;
	localparam logic [3:0] S_IDLE   = 4'd1;
	localparam logic [3:0] S_CHK    = 4'd2;
	localparam logic [3:0] S_LAST   = 4'd3;
	localparam logic [3:0] S_UP_RD  = 4'd4;
	localparam logic [3:0] S_UP_CMP = 4'd5;
	localparam logic [3:0] S_DN     = 4'd6;
	localparam logic [3:0] S_EX_RD  = 4'd7;
	localparam logic [3:0] S_EX_CHK = 4'd8;
	localparam logic [3:0] S_POP    = 4'd9;
	localparam logic [3:0] S_EX_LST = 4'd10;
	localparam logic [3:0] S_FRD    = 4'd11;
	localparam logic [3:0] S_FLAT   = 4'd12;
	localparam logic [3:0] S_M1     = 4'd13;
	localparam logic [3:0] S_M2     = 4'd14;
	localparam logic [3:0] S_OUT    = 4'd15;

	logic [3:0]        state_q, state_d;
	logic [AW-1:0]     clr_q, cnt_q, pos_q, pidx_s1, pick_q;
	logic [MD_W-1:0]   mode_q;
	logic [ID_W-1:0]   id_q, ow_q, bow_q, fid_q;
	logic [DL_W-1:0]   dlin_q, now_q, dl_q, best_q;
	logic              moved_q, pend_s1, found_q, none_q;
	logic [KW-1:0]     ki_q;
	logic [LIM_W-1:0]  fired_q, lim_q, lim_raw_q, lim_eff;
	logic [ST_W-1:0]   st_q;
	heap_ent_t         root_q;
	logic [CPU_W-1:0]  cpu_q;
	logic [DL_W-1:0]   off_q, prod;

	logic              h_we, t_we;
	logic [AW-1:0]     h_waddr, h_raddr, t_waddr, t_raddr;
	logic [HW-1:0]     h_wdata, h_rdata;
	logic [AW:0]       t_wdata, t_rdata;
	heap_ent_t         hr;

	logic [ID_W+AW-1:0] ext_in, ext_id, ext_ow, ext_hr, ext_bow, ext_root;
	logic [AW+RW-1:0]   par_prod;
	logic [AW-1:0]      par_c, lastpos_c;
	logic [CW-1:0]      child_c;
	logic               child_ok, in_range, tt_armed;
	logic               up_move, up_stop, up_to_dn, dn_issue, dn_decide, dn_lt;
	logic               emit_c, dn_init_c, more_c;
	logic [ST_W-1:0]    emit_st;
	logic [ID_W-1:0]    emit_fid;
	logic               emit_none;

	assign hr        = heap_ent_t'(h_rdata);
	assign ext_in    = {{AW{1'b0}}, timer_id};
	assign ext_id    = {{AW{1'b0}}, id_q};
	assign ext_ow    = {{AW{1'b0}}, ow_q};
	assign ext_hr    = {{AW{1'b0}}, hr.ow};
	assign ext_bow   = {{AW{1'b0}}, bow_q};
	assign ext_root  = {{AW{1'b0}}, root_q.ow};
	assign par_prod  = (AW+RW)'(pos_q - 1'b1) * (AW+RW)'(RECIP);
	assign par_c     = par_prod[SH +: AW];
	assign child_c   = CW'(pos_q) * CW'(HEAP_ARITY) + CW'(1) + CW'(ki_q);
	assign child_ok  = (ki_q < KW'(HEAP_ARITY)) && (child_c < CW'(cnt_q));
	assign lastpos_c = cnt_q - 1'b1;
	assign in_range  = 32'(id_q) < 32'(MAX_TIMERS);
	assign tt_armed  = t_rdata[AW];
	assign lim_eff   = (lim_raw_q == '0) ? LIM_W'(1) :
		((lim_raw_q > MAX_FIRE) ? MAX_FIRE : lim_raw_q);

	assign up_move   = (state_q == S_UP_CMP) && (dl_q < hr.dl);
	assign up_stop   = ((state_q == S_UP_RD) && (pos_q == '0)) ||
		((state_q == S_UP_CMP) && !up_move);
	assign up_to_dn  = up_stop && (mode_q == MODE_CANCEL) && !moved_q;
	assign dn_issue  = (state_q == S_DN) && child_ok;
	assign dn_decide = (state_q == S_DN) && !child_ok && !pend_s1;
	assign dn_lt     = pend_s1 && (hr.dl < best_q);
	assign more_c    = (mode_q == MODE_EXPIRE) && !none_q &&
		((fired_q + 1'b1) < lim_q) && (cnt_q != '0) && (root_q.dl <= now_q);
	assign busy      = (state_q != S_IDLE);

	qhtq_ram #(.WIDTH(HW), .DEPTH(MAX_TIMERS)) u_heap (
		.clk(clk), .we(h_we), .waddr(h_waddr), .wdata(h_wdata),
		.raddr(h_raddr), .rdata(h_rdata)
	);

	qhtq_ram #(.WIDTH(AW+1), .DEPTH(MAX_TIMERS)) u_table (
		.clk(clk), .we(t_we), .waddr(t_waddr), .wdata(t_wdata),
		.raddr(t_raddr), .rdata(t_rdata)
	);

	qhtq_cyc u_cyc (.clk(clk), .dl(root_q.dl), .cpu(cpu_q), .prod(prod));

	always_comb begin
		h_we      = 1'b0;
		h_waddr   = pos_q;
		h_wdata   = {dl_q, ow_q};
		h_raddr   = '0;
		t_we      = 1'b0;
		t_waddr   = ext_ow[AW-1:0];
		t_wdata   = {1'b1, pos_q};
		t_raddr   = ext_in[AW-1:0];
		state_d   = state_q;
		emit_c    = 1'b0;
		emit_st   = ST_FIRED;
		emit_fid  = '0;
		emit_none = 1'b0;
		dn_init_c = 1'b0;
		unique case (state_q)
			S_CLR: begin
				t_we    = 1'b1;
				t_waddr = clr_q;
				t_wdata = '0;
				if (clr_q == CNT_MAX) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (start) begin
					state_d = (mode == MODE_ARM || mode == MODE_CANCEL) ? S_CHK : S_EX_RD;
				end
			end
			S_CHK: begin
				h_raddr = lastpos_c;
				if (mode_q == MODE_ARM) begin
					if (!in_range || cnt_q == CNT_MAX) begin
						emit_c  = 1'b1;
						emit_st = tt_armed && in_range ? ST_ALREADY : ST_FULL;
					end else if (tt_armed) begin
						emit_c  = 1'b1;
						emit_st = ST_ALREADY;
					end else begin
						state_d = S_UP_RD;
					end
				end else begin
					if (!in_range || !tt_armed) begin
						emit_c  = 1'b1;
						emit_st = ST_NOT_ARMED;
					end else begin
						t_we    = 1'b1;
						t_waddr = ext_id[AW-1:0];
						t_wdata = '0;
						if (t_rdata[AW-1:0] < lastpos_c) begin
							state_d = S_LAST;
						end else begin
							emit_c  = 1'b1;
							emit_st = ST_CANCELLED;
						end
					end
				end
			end
			S_LAST: begin
				state_d = S_UP_RD;
			end
			S_UP_RD, S_UP_CMP: begin
				h_raddr = par_c;
				if (state_q == S_UP_RD && pos_q != '0) begin
					state_d = S_UP_CMP;
				end else if (up_move) begin
					h_we    = 1'b1;
					h_wdata = hr;
					t_we    = 1'b1;
					t_waddr = ext_hr[AW-1:0];
					state_d = S_UP_RD;
				end else if (up_to_dn) begin
					dn_init_c = 1'b1;
					state_d   = S_DN;
				end else begin
					h_we    = 1'b1;
					t_we    = 1'b1;
					emit_c  = 1'b1;
					emit_st = (mode_q == MODE_ARM) ? ST_ARMED : ST_CANCELLED;
				end
			end
			S_DN: begin
				h_raddr = child_c[AW-1:0];
				if (dn_decide) begin
					h_we = 1'b1;
					t_we = 1'b1;
					if (found_q) begin
						h_wdata = {best_q, bow_q};
						t_waddr = ext_bow[AW-1:0];
					end else begin
						emit_c   = 1'b1;
						emit_st  = (mode_q == MODE_EXPIRE) ? ST_FIRED : ST_CANCELLED;
						emit_fid = (mode_q == MODE_EXPIRE) ? root_q.ow : '0;
					end
				end
			end
			S_EX_RD: begin
				if (cnt_q == '0) begin
					emit_c    = 1'b1;
					emit_none = 1'b1;
				end else begin
					state_d = S_EX_CHK;
				end
			end
			S_EX_CHK: begin
				if (hr.dl <= now_q) begin
					state_d = S_POP;
				end else begin
					emit_c    = 1'b1;
					emit_none = 1'b1;
				end
			end
			S_POP: begin
				t_we    = 1'b1;
				t_waddr = ext_root[AW-1:0];
				t_wdata = '0;
				h_raddr = lastpos_c;
				if (lastpos_c != '0) begin
					state_d = S_EX_LST;
				end else begin
					emit_c   = 1'b1;
					emit_fid = root_q.ow;
				end
			end
			S_EX_LST: begin
				dn_init_c = 1'b1;
				state_d   = S_DN;
			end
			S_FRD:  state_d = S_FLAT;
			S_FLAT: state_d = S_M1;
			S_M1:   state_d = S_M2;
			S_M2:   state_d = S_OUT;
			S_OUT:  state_d = more_c ? S_POP : S_IDLE;
			default: state_d = S_IDLE;
		endcase
		if (emit_c) begin
			state_d = S_FRD;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_CLR;
			clr_q      <= '0;
			cnt_q      <= '0;
			pend_s1    <= 1'b0;
			done       <= 1'b0;
			fired_none <= 1'b0;
			cpu_q      <= CPU_W'(1);
			off_q      <= '0;
			lim_raw_q  <= MAX_FIRE;
		end else begin
			state_q <= state_d;
			done    <= 1'b0;
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_CPU:    cpu_q     <= cfg_data[CPU_W-1:0];
					CFG_OFFSET: off_q     <= cfg_data;
					CFG_LIMIT:  lim_raw_q <= cfg_data[LIM_W-1:0];
					default: ;
				endcase
			end
			if (state_q == S_CLR) begin
				clr_q <= clr_q + 1'b1;
			end
			if (state_q == S_IDLE && start) begin
				mode_q  <= (mode == MODE_ARM || mode == MODE_CANCEL) ? mode : MODE_EXPIRE;
				id_q    <= timer_id;
				dlin_q  <= due_us;
				now_q   <= now_us;
				fired_q <= '0;
				lim_q   <= lim_eff;
			end
			if (state_q == S_CHK && !emit_c) begin
				if (mode_q == MODE_ARM) begin
					cnt_q   <= cnt_q + 1'b1;
					pos_q   <= cnt_q;
					dl_q    <= dlin_q;
					ow_q    <= id_q;
					moved_q <= 1'b0;
				end else begin
					pos_q  <= t_rdata[AW-1:0];
				end
			end
			if (state_q == S_CHK && mode_q == MODE_CANCEL && in_range && tt_armed) begin
				cnt_q <= lastpos_c;
			end
			if (state_q == S_LAST) begin
				dl_q    <= hr.dl;
				ow_q    <= hr.ow;
				moved_q <= 1'b0;
			end
			if (up_move) begin
				pos_q   <= par_c;
				moved_q <= 1'b1;
			end
			if (state_q == S_EX_CHK) begin
				root_q <= hr;
			end
			if (state_q == S_POP) begin
				cnt_q <= lastpos_c;
			end
			if (state_q == S_EX_LST) begin
				dl_q  <= hr.dl;
				ow_q  <= hr.ow;
				pos_q <= '0;
			end
			if (dn_init_c) begin
				ki_q    <= '0;
				pend_s1 <= 1'b0;
				found_q <= 1'b0;
				best_q  <= (state_q == S_EX_LST) ? hr.dl : dl_q;
			end
			if (state_q == S_DN) begin
				pend_s1 <= dn_issue;
				if (dn_issue) begin
					ki_q    <= ki_q + 1'b1;
					pidx_s1 <= child_c[AW-1:0];
				end
				if (dn_lt) begin
					best_q  <= hr.dl;
					bow_q   <= hr.ow;
					pick_q  <= pidx_s1;
					found_q <= 1'b1;
				end
				if (dn_decide && found_q) begin
					pos_q   <= pick_q;
					ki_q    <= '0;
					found_q <= 1'b0;
					best_q  <= dl_q;
				end
			end
			if (emit_c) begin
				st_q   <= emit_st;
				fid_q  <= emit_fid;
				none_q <= emit_none;
			end
			if (state_q == S_FLAT && cnt_q != '0) begin
				root_q <= hr;
			end
			if (state_q == S_OUT) begin
				done              <= 1'b1;
				status            <= st_q;
				fired_id          <= fid_q;
				fired_none        <= none_q;
				last              <= !more_c;
				earliest_deadline <= (cnt_q != '0) ? root_q.dl : '0;
				next_event_cycle  <= (cnt_q != '0) ? prod + off_q : '1;
				if (mode_q == MODE_EXPIRE && !none_q) begin
					fired_q <= fired_q + 1'b1;
				end
			end
		end
	end

	`QA_IMPLY(a_last_idle, clk, arst_n, done && last, !busy, "last item result while busy")
	`QA_IMPLY(a_more_busy, clk, arst_n, done && !last, busy, "idle before final result")
	`QA_NEXT(a_accept, clk, arst_n, start && !busy, busy, "accepted item did not start")
	`QA_IMPLY(a_none_last, clk, arst_n, done && fired_none, last, "fired_none off final result")
	`QA_IMPLY(a_cnt_cap, clk, arst_n, 1'b1, cnt_q <= CNT_MAX, "heap count over capacity")
endmodule

// File: tb/sv/tb_quad_heap_timer_queue.sv
`timescale 1ns / 100ps
// Self-checking testbench of quad_heap_timer_queue: arm, cancel and expire items
// are driven under random gaps and checked against a heap predictor in a scoreboard.
// Depends on qhtq_pkg and the RTL of the block.
module tb_quad_heap_timer_queue;
	import qhtq_pkg::*;

	typedef struct {
		logic [ST_W-1:0] st;
		logic [ID_W-1:0] id;
		logic [DL_W-1:0] early;
		logic [DL_W-1:0] cyc;
		logic            none;
		logic            fin;
	} timer_result_t;

	class expiry_scoreboard;
		logic [DL_W-1:0]  heap_dl [1024];
		logic [ID_W-1:0]  heap_ow [1024];
		logic [ID_W-1:0]  slot_of [1024];
		bit               armed [1024];
		int               count;
		logic [CPU_W-1:0] cpu;
		logic [DL_W-1:0]  offset;
		logic [LIM_W-1:0] limit;
		timer_result_t    pending_results[$];
		int               errors;
		int               items;
		int               results;
		int               fires;

		function new();
			cpu = 1;
			offset = 0;
			limit = 64;
			count = 0;
			errors = 0;
			items = 0;
			results = 0;
			fires = 0;
			foreach (armed[i]) armed[i] = 0;
		endfunction

		function void write_reg(logic [CIX_W-1:0] idx, logic [CFG_W-1:0] data);
			if (idx == CFG_CPU) cpu = data[CPU_W-1:0];
			else if (idx == CFG_OFFSET) offset = data;
			else if (idx == CFG_LIMIT) limit = data[LIM_W-1:0];
		endfunction

		function void put(int s, logic [DL_W-1:0] dl, logic [ID_W-1:0] ow);
			heap_dl[s] = dl;
			heap_ow[s] = ow;
			slot_of[ow] = s;
		endfunction

		function void sift_up(int i);
			logic [DL_W-1:0] dl;
			logic [ID_W-1:0] ow;
			int p;
			dl = heap_dl[i];
			ow = heap_ow[i];
			while (i > 0) begin
				p = (i - 1) / 4;
				if (dl >= heap_dl[p]) break;
				put(i, heap_dl[p], heap_ow[p]);
				put(p, dl, ow);
				i = p;
			end
		endfunction

		function void sink_entry(int i, int n);
			logic [DL_W-1:0] dl, best;
			logic [ID_W-1:0] ow;
			int pick;
			dl = heap_dl[i];
			ow = heap_ow[i];
			forever begin
				best = dl;
				pick = -1;
				for (int j = i * 4 + 1; j <= i * 4 + 4 && j < n; j++) begin
					if (heap_dl[j] < best) begin
						best = heap_dl[j];
						pick = j;
					end
				end
				if (pick < 0) break;
				put(i, heap_dl[pick], heap_ow[pick]);
				put(pick, dl, ow);
				i = pick;
			end
		endfunction

		function void push_result(logic [ST_W-1:0] st, logic [ID_W-1:0] id, logic none,
				logic fin);
			timer_result_t r;
			r.st = st;
			r.id = id;
			r.none = none;
			r.fin = fin;
			r.early = 0;
			r.cyc = '1;
			if (count > 0) begin
				r.early = heap_dl[0];
				r.cyc = heap_dl[0] * {48'd0, cpu} + offset;
			end
			pending_results.push_back(r);
		endfunction

		function void note_item(logic [MD_W-1:0] md, logic [ID_W-1:0] id,
				logic [DL_W-1:0] dl, logic [DL_W-1:0] now);
			int s, lp, lim, n_fired;
			logic [ID_W-1:0] ow;
			items++;
			if (md == MODE_ARM) begin
				if (armed[id]) push_result(ST_ALREADY, 0, 0, 1);
				else if (count >= 1023) push_result(ST_FULL, 0, 0, 1);
				else begin
					s = count;
					count++;
					put(s, dl, id);
					sift_up(s);
					armed[id] = 1;
					push_result(ST_ARMED, 0, 0, 1);
				end
			end else if (md == MODE_CANCEL) begin
				if (!armed[id]) push_result(ST_NOT_ARMED, 0, 0, 1);
				else begin
					armed[id] = 0;
					s = slot_of[id];
					lp = count - 1;
					count = lp;
					if (s < lp) begin
						put(s, heap_dl[lp], heap_ow[lp]);
						sift_up(s);
						sink_entry(s, count);
					end
					push_result(ST_CANCELLED, 0, 0, 1);
				end
			end else begin
				lim = (limit == 0) ? 1 : (limit > MAX_FIRE) ? 64 : int'(limit);
				n_fired = 0;
				while (n_fired < lim && count > 0 && heap_dl[0] <= now) begin
					ow = heap_ow[0];
					count--;
					if (count > 0) begin
						put(0, heap_dl[count], heap_ow[count]);
						sink_entry(0, count);
					end
					armed[ow] = 0;
					push_result(ST_FIRED, ow, 0, 0);
					n_fired++;
				end
				fires += n_fired;
				if (n_fired == 0) push_result(ST_FIRED, 0, 1, 1);
				else pending_results[$].fin = 1;
			end
		endfunction

		task report(string msg);
			errors++;
			$display("[%0t] mismatch: %s", $time, msg);
		endtask

		task check_result(timer_result_t got);
			timer_result_t exp;
			results++;
			if (pending_results.size() == 0) begin
				report("result with no item outstanding");
				return;
			end
			exp = pending_results.pop_front();
			if (got.st !== exp.st)
				report($sformatf("status %0d, wanted %0d", got.st, exp.st));
			if (got.id !== exp.id)
				report($sformatf("fired_id %0d, wanted %0d", got.id, exp.id));
			if (got.early !== exp.early)
				report($sformatf("earliest_deadline %h, wanted %h", got.early, exp.early));
			if (got.cyc !== exp.cyc)
				report($sformatf("next_event_cycle %h, wanted %h", got.cyc, exp.cyc));
			if (got.none !== exp.none)
				report($sformatf("fired_none %b, wanted %b", got.none, exp.none));
			if (got.fin !== exp.fin)
				report($sformatf("last %b, wanted %b", got.fin, exp.fin));
		endtask
	endclass

	logic             clk = 0;
	logic             arst_n = 0;
	logic             start = 0;
	logic             busy;
	logic [MD_W-1:0]  mode = MODE_ARM;
	logic [ID_W-1:0]  timer_id = 0;
	logic [DL_W-1:0]  due_us = 0;
	logic [DL_W-1:0]  now_us = 0;
	logic             cfg_we = 0;
	logic [CIX_W-1:0] cfg_index = CFG_CPU;
	logic [CFG_W-1:0] cfg_data = 0;
	logic             done;
	logic [ST_W-1:0]  status;
	logic [ID_W-1:0]  fired_id;
	logic [DL_W-1:0]  earliest_deadline;
	logic [DL_W-1:0]  next_event_cycle;
	logic             fired_none;
	logic             last;

	expiry_scoreboard sb = new();

	quad_heap_timer_queue dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .mode(mode),
		.timer_id(timer_id), .due_us(due_us), .now_us(now_us),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data), .done(done),
		.status(status), .fired_id(fired_id), .earliest_deadline(earliest_deadline),
		.next_event_cycle(next_event_cycle), .fired_none(fired_none), .last(last)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		timer_result_t r;
		if (arst_n && done) begin
			r.st = status;
			r.id = fired_id;
			r.early = earliest_deadline;
			r.cyc = next_event_cycle;
			r.none = fired_none;
			r.fin = last;
			sb.check_result(r);
		end
	end

	task send_item(logic [MD_W-1:0] md, logic [ID_W-1:0] id, logic [DL_W-1:0] dl,
			logic [DL_W-1:0] now);
		int gap;
		start <= 1;
		mode <= md;
		timer_id <= id;
		due_us <= dl;
		now_us <= now;
		do @(posedge clk); while (busy !== 1'b0);
		sb.note_item(md, id, dl, now);
		gap = $urandom_range(0, 8);
		if (gap > 0) begin
			start <= 0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task drain();
		start <= 0;
		do @(posedge clk); while (sb.pending_results.size() != 0 || busy !== 1'b0);
		repeat (20) @(posedge clk);
	endtask

	task write_reg(logic [CIX_W-1:0] idx, logic [CFG_W-1:0] data);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_we <= 0;
		sb.write_reg(idx, data);
	endtask

	function logic [DL_W-1:0] pick_time();
		if ($urandom_range(0, 9) == 0) return {$urandom, $urandom};
		return DL_W'($urandom_range(0, 1000));
	endfunction

	task random_item();
		int r;
		logic [MD_W-1:0] md;
		logic [ID_W-1:0] id;
		r = $urandom_range(0, 99);
		md = (r < 45) ? MODE_ARM : (r < 70) ? MODE_CANCEL : (r < 95) ? MODE_EXPIRE : 2'd3;
		id = ($urandom_range(0, 7) == 0) ? ID_W'($urandom) : ID_W'($urandom_range(0, 31));
		send_item(md, id, pick_time(), pick_time());
	endtask

	task random_phase(int n);
		for (int k = 0; k < n; k++) begin
			random_item();
			if (k == n / 2 && $urandom_range(0, 1)) drain();
		end
		drain();
	endtask

	initial begin
		#50ms;
		$display("tb_quad_heap_timer_queue failed");
		$finish;
	end

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		send_item(MODE_EXPIRE, 0, 0, '1);
		send_item(MODE_ARM, 0, 0, 0);
		send_item(MODE_ARM, 1023, '1, 0);
		send_item(MODE_ARM, 0, 5, 0);
		send_item(MODE_ARM, 5, 100, 0);
		send_item(MODE_ARM, 6, 100, 0);
		send_item(MODE_ARM, 7, 40, 0);
		send_item(MODE_ARM, 8, 100, 0);
		send_item(MODE_CANCEL, 9, 0, 0);
		send_item(MODE_CANCEL, 7, 0, 0);
		send_item(MODE_CANCEL, 7, 0, 0);
		send_item(2'd3, 0, 0, 0);
		send_item(MODE_EXPIRE, 0, 0, 99);
		send_item(MODE_ARM, 682, 64'h5555_5555_5555_5555, 0);
		send_item(MODE_ARM, 341, 64'haaaa_aaaa_aaaa_aaaa, 0);
		send_item(MODE_CANCEL, 5, 0, 0);
		send_item(MODE_EXPIRE, 0, 0, 64'haaaa_aaaa_aaaa_aaaa);
		send_item(MODE_EXPIRE, 0, 0, '1);
		drain();

		write_reg(CFG_CPU, 65535);
		write_reg(CFG_OFFSET, '1);
		write_reg(CFG_LIMIT, 1);
		random_phase(45);

		write_reg(CFG_CPU, 0);
		write_reg(CFG_OFFSET, {$urandom, $urandom});
		write_reg(CFG_LIMIT, 0);
		random_phase(35);

		write_reg(CFG_CPU, CFG_W'($urandom_range(1, 65535)));
		write_reg(CFG_OFFSET, 0);
		write_reg(CFG_LIMIT, 127);
		random_phase(50);

		// Empty the heap in bursts of the full limit.
		write_reg(CFG_LIMIT, 64);
		write_reg(CFG_CPU, 1);
		while (sb.count > 0) send_item(MODE_EXPIRE, 0, 0, '1);
		drain();
		repeat (50) @(posedge clk);

		$display("Ran %0d items through arm, cancel and expire under several settings.",
			sb.items);
		$display("Checked %0d results, %0d of them fired timers; %0d mismatches.",
			sb.results, sb.fires, sb.errors);
		if (sb.errors == 0 && sb.pending_results.size() == 0)
			$display("tb_quad_heap_timer_queue passed");
		else
			$display("tb_quad_heap_timer_queue failed");
		$finish;
	end
endmodule
